[hw/rtl/stok_pkg.sv]
package stok_pkg;

    localparam int CntWidthDefault = 24;

    typedef enum logic [1:0] {
        K_VALUE = 2'd0,
        K_TOKEN = 2'd1,
        K_ERROR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        TK_IDENT    = 4'd0,
        TK_STRING   = 4'd1,
        TK_BINOP    = 4'd2,
        TK_INT      = 4'd3,
        TK_EOF      = 4'd4,
        TK_SEMI     = 4'd5,
        TK_LPAREN   = 4'd6,
        TK_RPAREN   = 4'd7,
        TK_ASSIGN   = 4'd8,
        TK_VAR      = 4'd9,
        TK_CONST    = 4'd10,
        TK_COMMA    = 4'd11,
        TK_FUNCTION = 4'd12,
        TK_LBRACE   = 4'd13,
        TK_RBRACE   = 4'd14
    } t_tok;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_UNKNOWN  = 2'd1,
        ERR_STRING   = 2'd2,
        ERR_COMMENT  = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_IDENT  = 3'd1,
        M_NUMBER = 3'd2,
        M_STRING = 3'd3,
        M_LINE   = 3'd4,
        M_BLOCK  = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  token_kind;
        logic [7:0]  value_byte;
        logic [23:0] line_no;
        logic [23:0] start_column;
        logic [23:0] end_column;
        logic [1:0]  error_code;
        logic        last_result;
    } t_out;

    localparam int MaxRes = 4;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // token code of a single-character token, valid flag in msb
    function automatic logic [4:0] char_tok(input logic [7:0] c);
        case (c)
            ";": return {1'b1, TK_SEMI};
            "(": return {1'b1, TK_LPAREN};
            ")": return {1'b1, TK_RPAREN};
            "+", "-", "*", "%": return {1'b1, TK_BINOP};
            "=": return {1'b1, TK_ASSIGN};
            ",": return {1'b1, TK_COMMA};
            "{": return {1'b1, TK_LBRACE};
            "}": return {1'b1, TK_RBRACE};
            default: return 5'd0;
        endcase
    endfunction

    // keyword character at position p, 0 past the end
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] p);
        logic [63:0] s;
        s = 64'd0;
        case (k)
            2'd0: s = {"var", 40'd0};
            2'd1: s = {"const", 24'd0};
            default: s = "function";
        endcase
        return (p < 4'd8) ? s[63 - 8*p[2:0] -: 8] : 8'd0;
    endfunction

endpackage

[hw/rtl/script_tokenizer.sv]
// Latency: an input beat's first result is valid the cycle after acceptance.
// Throughput: one byte per cycle while each byte yields at most one result and
// i_ready is held high; a byte with N results (up to 4) hands them out one by one,
// the next byte being accepted in the cycle its last result leaves the result buffer.
// Reset: synchronous, active low; scanner returns to normal mode at line 1, column 1.
module script_tokenizer
    import stok_pkg::*;
#(
    parameter int COUNTER_WIDTH = CntWidthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic [2:0]        count;
    t_out [MaxRes-1:0] res;
    logic              can_load, go;

    assign o_ready = can_load;
    assign go      = i_valid && can_load;

    stok_core #(.CNT_W(COUNTER_WIDTH)) u_core (
        .i_clk, .i_rst_n, .i_go(go), .i_beat(i_data), .o_count(count), .o_res(res)
    );

    stok_outq u_outq (
        .i_clk, .i_rst_n, .i_load(go), .i_count(count), .i_res(res),
        .o_can_load(can_load), .o_valid, .o_data, .i_ready
    );

endmodule

[hw/rtl/stok_core.sv]
module stok_core
    import stok_pkg::*;
#(
    parameter int CNT_W = CntWidthDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  t_in                      i_beat,
    output logic [2:0]               o_count,
    output t_out [MaxRes-1:0]        o_res
);

    localparam logic [CNT_W-1:0] CntMax = '1;
    localparam logic [CNT_W-1:0] One = CNT_W'(1);

    t_mode            r_mode, n_mode;
    logic [7:0]       r_quote, n_quote;
    logic             r_slash, n_slash;
    logic             r_star, n_star;
    logic [CNT_W-1:0] r_line, n_line, r_col, n_col, r_tsc, n_tsc;
    logic [2:0]       r_kw, n_kw;
    logic [3:0]       r_ilen, n_ilen;
    logic             r_halt, n_halt;

    logic [CNT_W-1:0] l0, c0, l1, c1;
    logic [7:0]       c;
    logic             fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL; r_quote <= '0; r_slash <= 1'b0; r_star <= 1'b0;
            r_line <= One; r_col <= One; r_tsc <= '0; r_kw <= 3'b111;
            r_ilen <= '0; r_halt <= 1'b0;
        end else if (i_go) begin
            r_mode <= n_mode; r_quote <= n_quote; r_slash <= n_slash; r_star <= n_star;
            r_line <= n_line; r_col <= n_col; r_tsc <= n_tsc; r_kw <= n_kw;
            r_ilen <= n_ilen; r_halt <= n_halt;
        end
    end

    function automatic logic [23:0] w24(input logic [CNT_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[23:0];
    endfunction

    always_comb begin
        t_out   res [MaxRes];
        logic [2:0]  cnt;
        logic [4:0]  ct;
        logic [3:0]  tkc;
        logic        stop;
        c   = i_beat.byte_in;
        fin = i_beat.final_byte;
        for (int i = 0; i < MaxRes; i++) res[i] = '0;
        cnt = '0; ct = '0; tkc = '0; stop = 1'b0;
        n_mode = r_mode; n_quote = r_quote; n_slash = r_slash; n_star = r_star;
        n_line = r_line; n_col = r_col; n_tsc = r_tsc; n_kw = r_kw;
        n_ilen = r_ilen; n_halt = r_halt;

        l0 = r_line; c0 = r_col;
        if (c == 8'h0d || c == 8'h0a) begin
            l1 = (r_line != CntMax) ? r_line + One : r_line;
            c1 = One;
        end else begin
            l1 = r_line;
            c1 = (r_col != CntMax) ? r_col + One : r_col;
        end

        if (r_halt) begin
            if (fin) begin
                n_mode = M_NORMAL; n_quote = '0; n_slash = 1'b0; n_star = 1'b0;
                n_line = One; n_col = One; n_tsc = '0; n_kw = 3'b111;
                n_ilen = '0; n_halt = 1'b0;
            end
        end else begin
            n_line = l1; n_col = c1;
            // ident/number: extend on a matching byte, else token close at the byte that ends it
            if (r_mode == M_IDENT || r_mode == M_NUMBER) begin
                if (r_mode == M_IDENT && (is_alpha(c) || is_digit(c) || c == "_")) begin
                    for (int k = 0; k < 3; k++)
                        if (r_kw[k] && (r_ilen >= ((k == 0) ? 4'd3 : (k == 1) ? 4'd5 : 4'd8)
                                || kw_char(2'(k), r_ilen) != c))
                            n_kw[k] = 1'b0;
                    if (r_ilen < 4'd15) n_ilen = r_ilen + 4'd1;
                    res[cnt[1:0]] = '{K_VALUE, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                    stop = 1'b1;
                    if (fin) begin
                        tkc = TK_IDENT;
                        if (n_kw[0] && n_ilen == 4'd3) tkc = TK_VAR;
                        if (n_kw[1] && n_ilen == 4'd5) tkc = TK_CONST;
                        if (n_kw[2] && n_ilen == 4'd8) tkc = TK_FUNCTION;
                        res[cnt[1:0]] = '{K_TOKEN, tkc, 8'd0, w24(l0), w24(r_tsc), w24(c1),
                                     ERR_NONE, 1'b0};
                        cnt = cnt + 3'd1;
                    end
                end else if (r_mode == M_NUMBER && is_digit(c)) begin
                    res[cnt[1:0]] = '{K_VALUE, TK_INT, c, w24(l0), w24(c0), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                    stop = 1'b1;
                    if (fin) begin
                        res[cnt[1:0]] = '{K_TOKEN, TK_INT, 8'd0, w24(l0), w24(r_tsc), w24(c1),
                                     ERR_NONE, 1'b0};
                        cnt = cnt + 3'd1;
                    end
                end else begin
                    tkc = TK_INT;
                    if (r_mode == M_IDENT) begin
                        tkc = TK_IDENT;
                        if (r_kw[0] && r_ilen == 4'd3) tkc = TK_VAR;
                        if (r_kw[1] && r_ilen == 4'd5) tkc = TK_CONST;
                        if (r_kw[2] && r_ilen == 4'd8) tkc = TK_FUNCTION;
                    end
                    res[cnt[1:0]] = '{K_TOKEN, tkc, 8'd0, w24(l0), w24(r_tsc), w24(c0),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                    n_mode = M_NORMAL;
                end
                if (stop) n_mode = r_mode;
            end else if (r_mode == M_STRING) begin
                stop = 1'b1;
                if (c == r_quote) begin
                    n_mode = M_NORMAL;
                    res[cnt[1:0]] = '{K_TOKEN, TK_STRING, 8'd0, w24(l1), w24(r_tsc), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                end else begin
                    res[cnt[1:0]] = '{K_VALUE, TK_STRING, c, w24(l0), w24(c0), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                    if (fin) begin
                        res[cnt[1:0]] = '{K_ERROR, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                     ERR_STRING, 1'b0};
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                    end
                end
            end else if (r_mode == M_LINE) begin
                stop = 1'b1;
                if (c == 8'h0a) n_mode = M_NORMAL;
            end else if (r_mode == M_BLOCK) begin
                stop = 1'b1;
                if (r_star && c == "/") begin
                    n_mode = M_NORMAL; n_star = 1'b0;
                end else begin
                    n_star = (c == "*");
                    if (fin) begin
                        res[cnt[1:0]] = '{K_ERROR, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                     ERR_COMMENT, 1'b0};
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                    end
                end
            end else if (r_mode != M_NORMAL) begin
                n_mode = M_NORMAL;
            end else if (r_slash) begin
                n_slash = 1'b0;
                if (c == "/") begin
                    n_mode = M_LINE; stop = 1'b1;
                end else if (c == "*") begin
                    n_mode = M_BLOCK; n_star = 1'b0; stop = 1'b1;
                    if (fin) begin
                        res[cnt[1:0]] = '{K_ERROR, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                     ERR_COMMENT, 1'b0};
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                    end
                end else begin
                    res[cnt[1:0]] = '{K_TOKEN, TK_BINOP, "/", w24(l0), w24(r_tsc), w24(c0),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                end
            end

            // normal scan of this byte
            if (!stop) begin
                ct = char_tok(c);
                if (is_space(c)) begin
                end else if (c == "/") begin
                    if (fin) begin
                        res[cnt[1:0]] = '{K_TOKEN, TK_BINOP, c, w24(l0), w24(c0), w24(c1),
                                     ERR_NONE, 1'b0};
                        cnt = cnt + 3'd1;
                    end else begin
                        n_slash = 1'b1; n_tsc = c0;
                    end
                end else if (ct[4]) begin
                    res[cnt[1:0]] = '{K_TOKEN, ct[3:0], c, w24(l0), w24(c0), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                end else if (c == 8'h22 || c == 8'h27) begin
                    n_quote = c; n_tsc = c0; n_mode = M_STRING;
                    if (fin) begin
                        res[cnt[1:0]] = '{K_ERROR, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                     ERR_STRING, 1'b0};
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                    end
                end else if (is_digit(c)) begin
                    n_mode = M_NUMBER; n_tsc = c0;
                    res[cnt[1:0]] = '{K_VALUE, TK_INT, c, w24(l0), w24(c0), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                    if (fin) begin
                        res[cnt[1:0]] = '{K_TOKEN, TK_INT, 8'd0, w24(l0), w24(c0), w24(c1),
                                     ERR_NONE, 1'b0};
                        cnt = cnt + 3'd1;
                    end
                end else if (is_alpha(c)) begin
                    n_mode = M_IDENT; n_tsc = c0; n_ilen = 4'd1;
                    n_kw = {c == "f", c == "c", c == "v"};
                    res[cnt[1:0]] = '{K_VALUE, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                    // single letter is never a keyword
                    if (fin) begin
                        res[cnt[1:0]] = '{K_TOKEN, TK_IDENT, 8'd0, w24(l0), w24(c0), w24(c1),
                                     ERR_NONE, 1'b0};
                        cnt = cnt + 3'd1;
                    end
                end else begin
                    res[cnt[1:0]] = '{K_ERROR, TK_IDENT, c, w24(l0), w24(c0), w24(c1),
                                 ERR_UNKNOWN, 1'b0};
                    cnt = cnt + 3'd1;
                    n_halt = 1'b1;
                end
            end

            if (fin) begin
                if (!n_halt) begin
                    res[cnt[1:0]] = '{K_TOKEN, TK_EOF, 8'd0, w24(l1), w24(c1), w24(c1),
                                 ERR_NONE, 1'b0};
                    cnt = cnt + 3'd1;
                end
                n_mode = M_NORMAL; n_quote = '0; n_slash = 1'b0; n_star = 1'b0;
                n_line = One; n_col = One; n_tsc = '0; n_kw = 3'b111;
                n_ilen = '0; n_halt = 1'b0;
            end
        end

        for (int i = 0; i < MaxRes; i++) begin
            o_res[i] = res[i];
            o_res[i].last_result = (3'(i) + 3'd1 == cnt);
        end
        o_count = cnt;
    end

endmodule

[hw/rtl/stok_outq.sv]
module stok_outq
    import stok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [2:0]          i_count,
    input  t_out [MaxRes-1:0]   i_res,
    output logic                o_can_load,
    output logic                o_valid,
    output t_out                o_data,
    input  logic                i_ready
);

    t_out [MaxRes-1:0] r_buf;
    logic [2:0]        r_cnt, r_ptr;
    logic              take, last;

    assign o_valid    = (r_cnt != 3'd0);
    assign o_data     = r_buf[r_ptr[1:0]];
    assign take       = o_valid && i_ready;
    assign last       = take && (r_ptr + 3'd1 == r_cnt);
    // load when empty or the final pending beat leaves this cycle
    assign o_can_load = !o_valid || last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ptr <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_ptr <= '0;
        end else if (last) begin
            r_cnt <= '0;
            r_ptr <= '0;
        end else if (take) begin
            r_ptr <= r_ptr + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_buf <= i_res;
    end

endmodule

[hw/rtl/stok_checker.sv]
module stok_checker
    import stok_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.kind != 2'd3)
        else $error("bad result kind");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == K_ERROR |-> o_data.error_code != ERR_NONE
            && o_data.last_result)
        else $error("error beat malformed");

    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while results pending");

endmodule

bind script_tokenizer stok_checker u_chk (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready, .o_data
);
